// ===== rtl/dhk_pkg.sv =====
package dhk_pkg;

   // Default table size and derived field widths.
   localparam int TABLE_SLOTS_DEF = 512;
   localparam int LETTER_W        = 5;
   localparam int KEY_W           = 3 * LETTER_W;
   localparam int WORD_W          = 15;
   localparam int LETTER_BASE     = 26;
   localparam int MARK_W          = 2;
   localparam int SLOT_W          = MARK_W + KEY_W;
   localparam int SLOT_IDX_W      = 9;
   localparam int PROBE_W         = 10;

   // Request codes.
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_SEARCH = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DUP      = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // Slot marks.
   localparam logic [MARK_W-1:0] MARK_EMPTY    = 2'd0;
   localparam logic [MARK_W-1:0] MARK_OCCUPIED = 2'd1;
   localparam logic [MARK_W-1:0] MARK_TOMB     = 2'd2;

   typedef struct packed {
      logic [1:0]          func;
      logic [LETTER_W-1:0] key_first_letter;
      logic [LETTER_W-1:0] key_second_letter;
      logic [LETTER_W-1:0] key_third_letter;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic [PROBE_W-1:0]    probe_count;
      logic [PROBE_W-1:0]    entry_count;
   } rsp_type;

   // Result of the constant divider.
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] quot;
      logic [WORD_W-1:0] rem;
   } dhk_dm_type;

endpackage

// ===== rtl/double_hash_key_table_top.sv =====
// Double-hashing key table: an open-addressed table of TABLE_SLOTS slots keyed
// by a three-letter code. Each request item on the req_ channel is an insert,
// a search or a remove; each one produces exactly one result item on rsp_.
// Both channels use valid/ready and an item moves when both are high.
//
// After reset the block runs a clearing pass that marks every slot empty, one
// slot per cycle; req_ready stays low until the pass is done.
//
// Each item is captured, then the hash unit makes two passes through a
// three-stage reciprocal divider to give the home slot and the step; the
// probe loop then reads and judges the slots of the chain, and the result is
// posted. The probe loop is bound by the single read port of the slot memory.
// Items are processed one at a time. An unused request code answers at once.
//
// The result sits in an output register. While the receiver stalls, the block
// still accepts and works on the next item and holds that result until the
// output register frees up.
module double_hash_key_table_top import dhk_pkg::*; #(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam logic [IDX_W-1:0]   LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [IDX_W:0]     SLOTS_SUM = (IDX_W + 1)'(TABLE_SLOTS);
   localparam logic [CNT_W-1:0]   SLOTS_CNT = CNT_W'(TABLE_SLOTS);
   localparam logic [WORD_W-1:0]  MUL_HI    = WORD_W'(LETTER_BASE * LETTER_BASE);
   localparam logic [WORD_W-1:0]  MUL_MID   = WORD_W'(LETTER_BASE);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_HSTART = 7'b0000100,
      S_HWAIT1 = 7'b0001000,
      S_HWAIT2 = 7'b0010000,
      S_PROBE  = 7'b0100000,
      S_FIN    = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [1:0]        func_ff, func_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [WORD_W-1:0] w_ff, w_in;
   logic [IDX_W-1:0]  home_ff, home_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [IDX_W-1:0]  rd_pos_ff, rd_pos_in;
   logic [IDX_W-1:0]  ev_pos_ff, ev_pos_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  probes_ff, probes_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Slot memory and divider hookup.
   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [SLOT_W-1:0] wr_data, rd_data;
   logic              dv_start;
   logic [WORD_W-1:0] dv_x;
   dhk_dm_type        dv_res;

   // Probe evaluation.
   logic [MARK_W-1:0] mark;
   logic [KEY_W-1:0]  slot_key;
   logic              is_occ, is_match, is_empty, exhausted;
   logic [CNT_W-1:0]  probes_n, occ_inc, occ_dec;
   logic [IDX_W:0]    pos_sum;
   logic [IDX_W-1:0]  next_pos;
   logic              rsp_load;

   dhk_divmod #(.DIVISOR(TABLE_SLOTS)) u_divmod (
      .clock    (clock),
      .reset    (reset),
      .in_valid (dv_start),
      .in_x     (dv_x),
      .result   (dv_res)
   );

   dhk_slot_ram #(.DEPTH(TABLE_SLOTS), .ADDR_W(IDX_W)) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      mark      = rd_data[SLOT_W-1 -: MARK_W];
      slot_key  = rd_data[KEY_W-1:0];
      is_occ    = (mark == MARK_OCCUPIED);
      is_match  = is_occ && (slot_key == key_ff);
      is_empty  = (mark == MARK_EMPTY);
      probes_n  = probes_ff + CNT_W'(1);
      exhausted = (probes_n == SLOTS_CNT);
      occ_inc   = occ_ff + CNT_W'(1);
      occ_dec   = (occ_ff == '0) ? occ_ff : occ_ff - CNT_W'(1);

      // Next probe position: both terms are below the table size, so a
      // single subtract wraps the sum.
      pos_sum = {1'b0, rd_pos_ff} + {1'b0, step_ff};
      if (pos_sum >= SLOTS_SUM) begin
         pos_sum = pos_sum - SLOTS_SUM;
      end
      next_pos = pos_sum[IDX_W-1:0];
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      func_in   = func_ff;
      key_in    = key_ff;
      w_in      = w_ff;
      home_in   = home_ff;
      step_in   = step_ff;
      rd_pos_in = rd_pos_ff;
      ev_pos_in = ev_pos_ff;
      pend_in   = pend_ff;
      probes_in = probes_ff;
      occ_in    = occ_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = ev_pos_ff;
      wr_data   = {MARK_OCCUPIED, key_ff};
      rd_en     = 1'b0;
      rd_addr   = rd_pos_ff;
      dv_start  = 1'b0;
      dv_x      = w_ff;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {MARK_EMPTY, KEY_W'(0)};
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_data.func;
               key_in  = {req_data.key_first_letter, req_data.key_second_letter,
                          req_data.key_third_letter};
               w_in    = WORD_W'(req_data.key_first_letter) * MUL_HI
                       + WORD_W'(req_data.key_second_letter) * MUL_MID
                       + WORD_W'(req_data.key_third_letter);
               if (req_data.func == FUNC_NONE) begin
                  res_in.status      = ST_NOTFOUND;
                  res_in.slot_index  = '0;
                  res_in.probe_count = '0;
                  res_in.entry_count = PROBE_W'(occ_ff);
                  state_in           = S_FIN;
               end else begin
                  state_in = S_HSTART;
               end
            end
         end
         S_HSTART: begin
            dv_start = 1'b1;
            dv_x     = w_ff;
            state_in = S_HWAIT1;
         end
         S_HWAIT1: begin
            if (dv_res.valid) begin
               home_in  = IDX_W'(dv_res.rem);
               dv_start = 1'b1;
               dv_x     = dv_res.quot;
               state_in = S_HWAIT2;
            end
         end
         S_HWAIT2: begin
            if (dv_res.valid) begin
               // An even step is bumped to the next odd value.
               step_in   = IDX_W'(dv_res.rem) | IDX_W'(1);
               rd_pos_in = home_ff;
               pend_in   = 1'b0;
               probes_in = '0;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            // Each cycle starts the read of the next slot while the data of
            // the previous read is judged. A read started on the last cycle
            // is simply dropped.
            rd_en     = 1'b1;
            rd_addr   = rd_pos_ff;
            ev_pos_in = rd_pos_ff;
            rd_pos_in = next_pos;
            pend_in   = 1'b1;
            if (pend_ff) begin
               probes_in          = probes_n;
               res_in.probe_count = PROBE_W'(probes_n);
               res_in.slot_index  = '0;
               res_in.entry_count = PROBE_W'(occ_ff);
               if (func_ff == FUNC_INSERT) begin
                  if (is_match) begin
                     res_in.status = ST_DUP;
                     state_in      = S_FIN;
                  end else if (!is_occ) begin
                     wr_en              = 1'b1;
                     wr_data            = {MARK_OCCUPIED, key_ff};
                     occ_in             = occ_inc;
                     res_in.status      = ST_OK;
                     res_in.slot_index  = SLOT_IDX_W'(ev_pos_ff);
                     res_in.entry_count = PROBE_W'(occ_inc);
                     state_in           = S_FIN;
                  end else if (exhausted) begin
                     res_in.status = ST_FULL;
                     state_in      = S_FIN;
                  end
               end else begin
                  if (is_match) begin
                     if (func_ff == FUNC_REMOVE) begin
                        wr_en              = 1'b1;
                        wr_data            = {MARK_TOMB, key_ff};
                        occ_in             = occ_dec;
                        res_in.entry_count = PROBE_W'(occ_dec);
                     end
                     res_in.status     = ST_OK;
                     res_in.slot_index = SLOT_IDX_W'(ev_pos_ff);
                     state_in          = S_FIN;
                  end else if (is_empty || exhausted) begin
                     res_in.status = ST_NOTFOUND;
                     state_in      = S_FIN;
                  end
               end
               if (state_in == S_FIN) begin
                  pend_in = 1'b0;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loaded from the finished result once it is free.
   always_comb begin
      rsp_load     = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      rsp_data_in  = rsp_load ? res_ff : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      key_ff      <= key_in;
      w_ff        <= w_in;
      home_ff     <= home_in;
      step_ff     <= step_in;
      rd_pos_ff   <= rd_pos_in;
      ev_pos_ff   <= ev_pos_in;
      probes_ff   <= probes_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/dhk_divmod.sv =====
module dhk_divmod import dhk_pkg::*; #(
   parameter int DIVISOR = TABLE_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [WORD_W-1:0] in_x,
   output dhk_dm_type        result
);

   // Quotient estimate by reciprocal multiply; it is low by at most one,
   // and a single compare and subtract corrects it.
   localparam int SH      = 24;
   localparam int RECIP_W = SH - 2;
   localparam int PROD_W  = WORD_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << SH) / DIVISOR);
   localparam logic [WORD_W-1:0]  DIV_V = WORD_W'(DIVISOR);

   logic              v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [WORD_W-1:0] x1_ff, x1_in;
   logic [PROD_W-1:0] prod1_ff, prod1_in;
   logic [WORD_W-1:0] q2_ff, q2_in, r2_ff, r2_in;
   logic [WORD_W-1:0] q3_ff, q3_in, r3_ff, r3_in;
   logic [WORD_W-1:0] q_est;

   always_comb begin
      v1_in    = in_valid;
      x1_in    = in_x;
      prod1_in = PROD_W'(in_x) * PROD_W'(RECIP);

      q_est = WORD_W'(prod1_ff[PROD_W-1:SH]);
      v2_in = v1_ff;
      q2_in = q_est;
      r2_in = x1_ff - WORD_W'(q_est * DIV_V);

      v3_in = v2_ff;
      if (r2_ff >= DIV_V) begin
         q3_in = q2_ff + WORD_W'(1);
         r3_in = r2_ff - DIV_V;
      end else begin
         q3_in = q2_ff;
         r3_in = r2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
      x1_ff    <= x1_in;
      prod1_ff <= prod1_in;
      q2_ff    <= q2_in;
      r2_ff    <= r2_in;
      q3_ff    <= q3_in;
      r3_ff    <= r3_in;
   end

   assign result = '{valid: v3_ff, quot: q3_ff, rem: r3_ff};

endmodule

// ===== rtl/dhk_slot_ram.sv =====
module dhk_slot_ram import dhk_pkg::*; #(
   parameter int DEPTH  = TABLE_SLOTS_DEF,
   parameter int ADDR_W = $clog2(TABLE_SLOTS_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [SLOT_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [SLOT_W-1:0] rd_data
);

   // One word per slot: mark in the top bits, packed key below.
   logic [SLOT_W-1:0] mem [DEPTH];
   logic [SLOT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/dhk_checker.sv =====
module dhk_checker import dhk_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Entry count of the last delivered result.
   logic [PROBE_W-1:0] prev_cnt_ff, prev_cnt_in;
   logic               have_ff, have_in;

   always_comb begin
      prev_cnt_in = prev_cnt_ff;
      have_in     = have_ff;
      if (rsp_valid && rsp_ready) begin
         prev_cnt_in = rsp_data.entry_count;
         have_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      prev_cnt_ff <= prev_cnt_in;
   end

   // The clearing pass keeps requests out right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request accepted during the clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.slot_index == '0)
      else $error("failed request names a slot");

   a_hit_probed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_NOTFOUND |-> rsp_data.probe_count != '0)
      else $error("decision without a probe");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && have_ff |->
         rsp_data.entry_count == prev_cnt_ff ||
         rsp_data.entry_count == PROBE_W'(prev_cnt_ff + PROBE_W'(1)) ||
         prev_cnt_ff == PROBE_W'(rsp_data.entry_count + PROBE_W'(1)))
      else $error("entry count moved by more than one");

endmodule

bind double_hash_key_table_top dhk_checker u_dhk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== test/double_hash_key_table_top_test.sv =====
module double_hash_key_table_top_test;
   import dhk_pkg::*;

   localparam int N = TABLE_SLOTS_DEF;

   // Tail after the last result: hash pipeline plus a full probe sweep.
   localparam int TAIL_CYCLES = 16 + N;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Local copy of the table: slot marks, stored keys and the entry count.
   logic [MARK_W-1:0] slot_mark [N];
   logic [KEY_W-1:0]  slot_key  [N];
   int unsigned       occupied_total;

   // Results still owed by the block, oldest first.
   rsp_type pending_results [$];

   // Recently inserted keys, so that searches and removes mostly hit.
   logic [KEY_W-1:0] recent_keys [$];

   int error_count;
   int sender_idle_pct;
   int receiver_idle_pct;

   // One row of the directed part. When has_answer is set, the result is
   // written out by hand and replaces the computed one.
   typedef struct {
      req_type item;
      bit      has_answer;
      rsp_type answer;
   } stim_row_type;

   // The directed rows start from an empty table. Key AAA hashes to slot 0
   // with step 1; key A,T,S has W = 512, so it lands on slot 0 as well and
   // then moves on to slot 1. That pair covers a collision, a search that
   // passes a tombstone, and an insert that reuses a tombstone even though
   // the same key is still stored further down its probe chain (the table
   // then holds the key twice). Keys A,A,26 and A,B,A have the same W but
   // different bits, so they must stay separate entries.
   stim_row_type directed_rows [24] = '{
      '{'{FUNC_SEARCH, 5'd0,  5'd0,  5'd0},  1'b1, '{ST_NOTFOUND, 9'd0,   10'd1, 10'd0}},
      '{'{FUNC_REMOVE, 5'd0,  5'd0,  5'd0},  1'b1, '{ST_NOTFOUND, 9'd0,   10'd1, 10'd0}},
      '{'{FUNC_NONE,   5'd0,  5'd0,  5'd0},  1'b1, '{ST_NOTFOUND, 9'd0,   10'd0, 10'd0}},
      '{'{FUNC_INSERT, 5'd0,  5'd0,  5'd0},  1'b1, '{ST_OK,       9'd0,   10'd1, 10'd1}},
      '{'{FUNC_INSERT, 5'd0,  5'd0,  5'd0},  1'b1, '{ST_DUP,      9'd0,   10'd1, 10'd1}},
      '{'{FUNC_SEARCH, 5'd0,  5'd0,  5'd0},  1'b1, '{ST_OK,       9'd0,   10'd1, 10'd1}},
      '{'{FUNC_INSERT, 5'd25, 5'd25, 5'd25}, 1'b1, '{ST_OK,       9'd167, 10'd1, 10'd2}},
      '{'{FUNC_INSERT, 5'd31, 5'd31, 5'd31}, 1'b0, '0},
      '{'{FUNC_SEARCH, 5'd31, 5'd31, 5'd31}, 1'b0, '0},
      '{'{FUNC_INSERT, 5'd0,  5'd19, 5'd18}, 1'b0, '0},
      '{'{FUNC_REMOVE, 5'd0,  5'd0,  5'd0},  1'b0, '0},
      '{'{FUNC_SEARCH, 5'd0,  5'd19, 5'd18}, 1'b0, '0},
      '{'{FUNC_INSERT, 5'd0,  5'd19, 5'd18}, 1'b0, '0},
      '{'{FUNC_SEARCH, 5'd0,  5'd0,  5'd0},  1'b0, '0},
      '{'{FUNC_REMOVE, 5'd0,  5'd19, 5'd18}, 1'b0, '0},
      '{'{FUNC_REMOVE, 5'd0,  5'd19, 5'd18}, 1'b0, '0},
      '{'{FUNC_SEARCH, 5'd0,  5'd19, 5'd18}, 1'b0, '0},
      '{'{FUNC_INSERT, 5'd0,  5'd0,  5'd26}, 1'b0, '0},
      '{'{FUNC_INSERT, 5'd0,  5'd1,  5'd0},  1'b0, '0},
      '{'{FUNC_SEARCH, 5'd0,  5'd1,  5'd0},  1'b0, '0},
      '{'{FUNC_REMOVE, 5'd0,  5'd0,  5'd26}, 1'b0, '0},
      '{'{FUNC_NONE,   5'd31, 5'd31, 5'd31}, 1'b0, '0},
      '{'{FUNC_SEARCH, 5'd25, 5'd25, 5'd25}, 1'b0, '0},
      '{'{FUNC_REMOVE, 5'd25, 5'd25, 5'd25}, 1'b0, '0}
   };

   double_hash_key_table_top #(
      .TABLE_SLOTS(N)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Applies one request to the local table and returns the result that the
   // block must give for it. Probe i visits (home + i*step) mod N; the step
   // is forced odd, so a sweep of N probes reaches every slot.
   function automatic rsp_type apply_table_request(input req_type r);
      logic [KEY_W-1:0] key;
      int unsigned      word;
      int unsigned      home;
      int unsigned      stride;
      int unsigned      pos;
      rsp_type          res;
      key    = {r.key_first_letter, r.key_second_letter, r.key_third_letter};
      word   = int'(r.key_first_letter) * LETTER_BASE * LETTER_BASE
             + int'(r.key_second_letter) * LETTER_BASE + int'(r.key_third_letter);
      home   = word % N;
      stride = (word / N) % N;
      if (stride[0] == 1'b0) begin
         stride = stride + 1;
      end
      res = '{status: ST_NOTFOUND, slot_index: '0, probe_count: '0, entry_count: '0};
      if (r.func != FUNC_NONE) begin
         // Outcome when the whole sweep ends without a decision.
         res.status      = (r.func == FUNC_INSERT) ? ST_FULL : ST_NOTFOUND;
         res.probe_count = PROBE_W'(N);
         for (int i = 0; i < N; i++) begin
            pos = (home + i * stride) % N;
            if (slot_mark[pos] == MARK_OCCUPIED && slot_key[pos] == key) begin
               res.probe_count = PROBE_W'(i + 1);
               if (r.func == FUNC_INSERT) begin
                  res.status = ST_DUP;
               end else begin
                  res.status     = ST_OK;
                  res.slot_index = SLOT_IDX_W'(pos);
                  if (r.func == FUNC_REMOVE) begin
                     slot_mark[pos] = MARK_TOMB;
                     if (occupied_total > 0) begin
                        occupied_total = occupied_total - 1;
                     end
                  end
               end
               break;
            end else if (r.func == FUNC_INSERT && slot_mark[pos] != MARK_OCCUPIED) begin
               // An insert takes the first empty slot or tombstone it meets.
               slot_key[pos]   = key;
               slot_mark[pos]  = MARK_OCCUPIED;
               occupied_total  = occupied_total + 1;
               res.status      = ST_OK;
               res.slot_index  = SLOT_IDX_W'(pos);
               res.probe_count = PROBE_W'(i + 1);
               break;
            end else if (r.func != FUNC_INSERT && slot_mark[pos] == MARK_EMPTY) begin
               // Searches and removes step over tombstones but stop at empty.
               res.probe_count = PROBE_W'(i + 1);
               break;
            end
         end
      end
      res.entry_count = PROBE_W'(occupied_total);
      return res;
   endfunction

   // Mostly real letters, sometimes the codes above Z so every bit toggles.
   function automatic logic [LETTER_W-1:0] random_letter();
      if ($urandom_range(9) == 0) begin
         return LETTER_W'($urandom_range(31));
      end
      return LETTER_W'($urandom_range(LETTER_BASE - 1));
   endfunction

   // Random request: mostly operations on keys that were inserted lately,
   // so that the probe chains, duplicates and tombstones get exercised;
   // the rest use fresh keys or the unused request code.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         r.func = FUNC_INSERT;
      end else if (pick < 70) begin
         r.func = FUNC_SEARCH;
      end else if (pick < 95) begin
         r.func = FUNC_REMOVE;
      end else begin
         r.func = FUNC_NONE;
      end
      if (recent_keys.size() != 0 && $urandom_range(99) < 65) begin
         {r.key_first_letter, r.key_second_letter, r.key_third_letter} =
            recent_keys[$urandom_range(recent_keys.size() - 1)];
      end else begin
         r.key_first_letter  = random_letter();
         r.key_second_letter = random_letter();
         r.key_third_letter  = random_letter();
      end
      if (r.func == FUNC_INSERT) begin
         recent_keys.push_back({r.key_first_letter, r.key_second_letter,
                                r.key_third_letter});
         if (recent_keys.size() > 24) begin
            void'(recent_keys.pop_front());
         end
      end
      return r;
   endfunction

   // Offers one item starting at a falling edge, with an optional random
   // gap in front, and returns at the falling edge after it was accepted.
   // Valid is left high so that a following item goes out back to back.
   task automatic send_request(input req_type item, input bit has_answer,
                               input rsp_type answer);
      rsp_type computed;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      // The item went in at this edge; the table changes in the same order.
      computed = apply_table_request(item);
      pending_results.push_back(has_answer ? answer : computed);
      @(negedge clock);
   endtask

   // The sender holds off until the block has answered everything.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // The receiver decides at each falling edge whether to take a result.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Every result taken at a rising edge is checked against the oldest
   // outstanding expectation, field by field.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result item with no request outstanding: %p", rsp_data);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.slot_index !== want.slot_index) begin
               $error("slot_index: expected %0d, got %0d", want.slot_index,
                      rsp_data.slot_index);
               error_count++;
            end
            if (rsp_data.probe_count !== want.probe_count) begin
               $error("probe_count: expected %0d, got %0d", want.probe_count,
                      rsp_data.probe_count);
               error_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      rsp_data.entry_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog: far beyond the slowest legal run, including the clearing pass
   // after reset and full sweeps of the table during the fill phase.
   initial begin
      #8000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      req_type item;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data          = '0;
      rsp_ready         = 1'b0;
      error_count       = 0;
      occupied_total    = 0;
      sender_idle_pct   = 31;
      receiver_idle_pct = 69;
      foreach (slot_mark[k]) begin
         slot_mark[k] = MARK_EMPTY;
         slot_key[k]  = '0;
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The block clears its slot marks after reset; the first item simply
      // waits for req_ready.
      foreach (directed_rows[k]) begin
         send_request(directed_rows[k].item, directed_rows[k].has_answer,
                      directed_rows[k].answer);
      end
      wait_for_results();

      // Sender mostly busy, receiver mostly stalling.
      repeat (40) send_request(random_request(), 1'b0, '0);
      wait_for_results();

      // The other way round: gaps on the input, the output rarely stalls.
      sender_idle_pct   = 69;
      receiver_idle_pct = 31;
      repeat (40) send_request(random_request(), 1'b0, '0);
      wait_for_results();

      // Full rate on both sides.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      repeat (40) send_request(random_request(), 1'b0, '0);

      // Fill every slot with fresh random keys, so that long probe chains
      // and then the table-full and exhausted-sweep outcomes are reached.
      while (occupied_total < N) begin
         item.func              = FUNC_INSERT;
         item.key_first_letter  = LETTER_W'($urandom_range(31));
         item.key_second_letter = LETTER_W'($urandom_range(31));
         item.key_third_letter  = LETTER_W'($urandom_range(31));
         send_request(item, 1'b0, '0);
      end
      repeat (6) begin
         item.func              = ($urandom_range(1) == 0) ? FUNC_INSERT : FUNC_SEARCH;
         item.key_first_letter  = LETTER_W'($urandom_range(31));
         item.key_second_letter = LETTER_W'($urandom_range(31));
         item.key_third_letter  = LETTER_W'($urandom_range(31));
         send_request(item, 1'b0, '0);
      end
      // A few mixed items on the crowded table, removes and reinserts.
      repeat (20) send_request(random_request(), 1'b0, '0);
      wait_for_results();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d result items never arrived", pending_results.size());
         error_count++;
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
